// ===== rtl/pof_pkg.sv =====
`timescale 1ns / 1ps
// Package for the prime order filter: port widths, register indexes,
// verdict codes and the small prime tables. No dependencies.
package pof_pkg;

    localparam int unsigned CAND_W = 40;
    localparam int unsigned R_W    = 20;
    localparam int unsigned S_W    = 34;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned VERD_W = 3;
    localparam int unsigned OPW    = 64;
    localparam int unsigned NSP    = 14;
    localparam int unsigned NRED   = 3;

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [IDX_W-1:0]  t_cfg_idx;
    typedef logic [VERD_W-1:0] t_verdict;
    typedef logic [5:0]        t_sp;
    typedef logic [2:0]        t_lsel;

    localparam t_mode MODE_RELAY = 2'd0;
    localparam t_mode MODE_FORK  = 2'd1;

    localparam t_cfg_idx CFG_SHAPE = 2'd0;
    localparam t_cfg_idx CFG_R     = 2'd1;
    localparam t_cfg_idx CFG_S     = 2'd2;

    localparam t_verdict V_SMALL     = 3'd0;
    localparam t_verdict V_POWER     = 3'd1;
    localparam t_verdict V_COMPOSITE = 3'd2;
    localparam t_verdict V_NOTMULT   = 3'd3;
    localparam t_verdict V_HIT       = 3'd4;

    localparam t_lsel LS_R   = 3'd3;
    localparam t_lsel LS_S   = 3'd4;
    localparam t_lsel LS_END = 3'd5;

    localparam logic [R_W-1:0] R_RESET = 20'd43;
    localparam logic [7:0]     GCD_BASE = 8'd42;

    localparam t_sp SMALL_PRIMES [NSP] = '{
        6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19,
        6'd23, 6'd29, 6'd31, 6'd37, 6'd41, 6'd43, 6'd47
    };

    localparam t_sp REDUCE_PRIMES [NRED] = '{6'd2, 6'd3, 6'd7};

endpackage

// ===== rtl/prime_order_filter_top.sv =====
`timescale 1ns / 1ps
// Prime order filter: small prime sieve, gcd, bit-serial modular powers,
// trial division and order reduction in one sequenced datapath. Uses pof_pkg.
// A small prime reject ends after the sieve scan; otherwise the item takes
// two or three binary gcd runs, restoring divisions and modular powers (one
// serial add-double multiplier), and an odd candidate adds trial divisions.
// One item in flight; the next is taken once the result sits in the output
// register. Reset: synchronous, active low; r = 43, s = 0, relay mode.
module prime_order_filter_top #(
    parameter int unsigned CAND_BITS = 40
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [pof_pkg::CAND_W-1:0]     i_candidate,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [pof_pkg::CAND_W-1:0]     o_candidate_echo,
    output logic [pof_pkg::VERD_W-1:0]     o_verdict,
    output logic [pof_pkg::CAND_W-1:0]     o_order,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pof_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [pof_pkg::S_W-1:0]        i_cfg_data
);
    import pof_pkg::*;

    localparam int unsigned W  = CAND_BITS;
    localparam int unsigned CW = $clog2(W + 1);
    localparam int unsigned KW = $clog2(OPW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_GCD, S_GDIV, S_EDIV, S_POWE, S_TCHK, S_TDIV,
        S_RSEL, S_RDIV, S_RPOW, S_MMUL, S_MCHK, S_MDIV, S_EMIT
    } t_state;

    typedef enum logic [1:0] {G_IDLE, G_RUN, G_SHL} t_gst;
    typedef enum logic [1:0] {PW_IDLE, PW_STEP, PW_MUL} t_pwst;

    // configuration
    t_mode          r_mode;
    logic [R_W-1:0] r_fr;
    logic [S_W-1:0] r_fs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RELAY;
            r_fr   <= R_RESET;
            r_fs   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SHAPE: r_mode <= i_cfg_data[MODE_W-1:0];
                CFG_R:     r_fr   <= i_cfg_data[R_W-1:0];
                CFG_S:     r_fs   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // main registers
    t_state           r_state;
    logic [W-1:0]     r_p;
    logic [W-1:0]     r_c;
    logic [W-1:0]     r_n;
    logic [W-1:0]     r_scan;
    logic [CW-1:0]    r_scan_cnt;
    t_sp              r_sp_rem [NSP];
    logic [1:0]       r_gstep;
    t_lsel            r_lsel;
    t_verdict         r_verdict;
    logic [W-1:0]     r_td;
    logic [W+1:0]     r_tsq;
    logic [OPW-1:0]   r_mand;
    logic [OPW-1:0]   r_mm_a;
    logic [R_W-1:0]   r_mm_b;
    logic             r_gcd_go;
    logic [OPW-1:0]   r_gcd_a;
    logic [OPW-1:0]   r_gcd_b;
    logic             r_div_go;
    logic [W-1:0]     r_div_a;
    logic [OPW-1:0]   r_div_b;
    logic             r_pow_go;
    logic [W-1:0]     r_pow_e;
    logic                 r_out_valid;
    logic [CAND_W-1:0]    r_out_cand;
    t_verdict             r_out_verdict;
    logic [CAND_W-1:0]    r_out_order;

    // unit registers
    t_gst             r_gst;
    logic [OPW-1:0]   r_ga;
    logic [OPW-1:0]   r_gb;
    logic [KW-1:0]    r_gk;
    logic             r_g_done;
    logic [W-1:0]     r_dq;
    logic [OPW-1:0]   r_drem;
    logic [OPW-1:0]   r_dd;
    logic [CW-1:0]    r_dcnt;
    logic             r_d_busy;
    logic             r_d_done;
    t_pwst            r_pwst;
    logic [W-1:0]     r_px;
    logic [W-1:0]     r_pb;
    logic [W-1:0]     r_pex;
    logic [W-1:0]     r_ma;
    logic [W-1:0]     r_mb;
    logic [W-1:0]     r_macc;
    logic             r_pw_sq;
    logic             r_pw_done;

    // combinational helpers
    logic [OPW-1:0]   cand_ext;
    logic [W-1:0]     p_in;
    logic [OPW-1:0]   p_ext;
    logic [OPW-1:0]   n_ext;
    t_sp              n_sp_rem [NSP];
    logic             sp_pass;
    logic [OPW-1:0]   l_cur;
    logic             relay;
    logic [W-1:0]     p_m1;

    assign cand_ext = OPW'(i_candidate);
    assign p_in     = cand_ext[W-1:0];
    assign p_ext    = OPW'(r_p);
    assign n_ext    = OPW'(r_n);
    assign relay    = (r_mode == MODE_RELAY);
    assign p_m1     = r_p - W'(1);

    always_comb begin
        logic [6:0] t2;
        sp_pass = 1'b1;
        for (int i = 0; i < NSP; i++) begin
            t2 = {r_sp_rem[i], r_scan[W-1]};
            n_sp_rem[i] = (t2 >= {1'b0, SMALL_PRIMES[i]}) ?
                          6'(t2 - {1'b0, SMALL_PRIMES[i]}) : t2[5:0];
            if (r_p != W'(SMALL_PRIMES[i]) && r_sp_rem[i] == '0)
                sp_pass = 1'b0;
        end
    end

    always_comb begin
        case (r_lsel)
            3'd0, 3'd1, 3'd2: l_cur = OPW'(REDUCE_PRIMES[r_lsel[1:0]]);
            LS_R:             l_cur = OPW'(r_fr);
            LS_S:             l_cur = OPW'(r_fs);
            default:          l_cur = '0;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_gcd_go    <= 1'b0;
            r_div_go    <= 1'b0;
            r_pow_go    <= 1'b0;
        end else begin
            r_gcd_go <= 1'b0;
            r_div_go <= 1'b0;
            r_pow_go <= 1'b0;
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_p        <= p_in;
                        r_scan     <= p_in;
                        r_scan_cnt <= CW'(W);
                        for (int i = 0; i < NSP; i++) r_sp_rem[i] <= '0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_scan_cnt != '0) begin
                        for (int i = 0; i < NSP; i++) r_sp_rem[i] <= n_sp_rem[i];
                        r_scan     <= {r_scan[W-2:0], 1'b0};
                        r_scan_cnt <= r_scan_cnt - CW'(1);
                    end else if (!sp_pass) begin
                        r_verdict <= V_SMALL;
                        r_n       <= '0;
                        r_state   <= S_EMIT;
                    end else if (r_p < W'(2)) begin
                        r_verdict <= V_POWER;
                        r_n       <= '0;
                        r_state   <= S_EMIT;
                    end else begin
                        r_c      <= p_m1;
                        r_gcd_go <= 1'b1;
                        r_gcd_a  <= OPW'(GCD_BASE);
                        r_gcd_b  <= OPW'(p_m1);
                        r_gstep  <= 2'd0;
                        r_state  <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_g_done) begin
                        r_div_go <= 1'b1;
                        r_div_a  <= r_c;
                        r_div_b  <= r_ga;
                        r_state  <= S_GDIV;
                    end
                end
                S_GDIV: begin
                    if (r_d_done) begin
                        r_c <= r_dq;
                        if (r_gstep == 2'd0) begin
                            r_gcd_go <= 1'b1;
                            r_gcd_a  <= OPW'(r_fr);
                            r_gcd_b  <= OPW'(r_dq);
                            r_gstep  <= 2'd1;
                            r_state  <= S_GCD;
                        end else if (r_gstep == 2'd1 && !relay) begin
                            r_gcd_go <= 1'b1;
                            r_gcd_a  <= OPW'(r_fs);
                            r_gcd_b  <= OPW'(r_dq);
                            r_gstep  <= 2'd2;
                            r_state  <= S_GCD;
                        end else begin
                            // e = (p-1) / remaining cofactor
                            r_div_go <= 1'b1;
                            r_div_a  <= p_m1;
                            r_div_b  <= OPW'(r_dq);
                            r_state  <= S_EDIV;
                        end
                    end
                end
                S_EDIV: begin
                    if (r_d_done) begin
                        r_n      <= r_dq;
                        r_pow_go <= 1'b1;
                        r_pow_e  <= r_dq;
                        r_state  <= S_POWE;
                    end
                end
                S_POWE: begin
                    if (r_pw_done) begin
                        r_lsel <= '0;
                        if (r_px != W'(1)) begin
                            r_verdict <= V_POWER;
                            r_n       <= '0;
                            r_state   <= S_EMIT;
                        end else if (!r_p[0]) begin
                            if (r_p == W'(2)) begin
                                r_state <= S_RSEL;
                            end else begin
                                r_verdict <= V_COMPOSITE;
                                r_n       <= '0;
                                r_state   <= S_EMIT;
                            end
                        end else begin
                            r_td    <= W'(3);
                            r_tsq   <= (W+2)'(9);
                            r_state <= S_TCHK;
                        end
                    end
                end
                S_TCHK: begin
                    if (r_tsq > (W+2)'(r_p)) begin
                        r_state <= S_RSEL;
                    end else begin
                        r_div_go <= 1'b1;
                        r_div_a  <= r_p;
                        r_div_b  <= OPW'(r_td);
                        r_state  <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (r_d_done) begin
                        if (r_drem == '0) begin
                            r_verdict <= V_COMPOSITE;
                            r_n       <= '0;
                            r_state   <= S_EMIT;
                        end else begin
                            // (d+2)^2 = d^2 + 4d + 4
                            r_td    <= r_td + W'(2);
                            r_tsq   <= r_tsq + ((W+2)'(r_td) << 2) + (W+2)'(4);
                            r_state <= S_TCHK;
                        end
                    end
                end
                S_RSEL: begin
                    if (r_lsel == LS_END) begin
                        r_mm_a <= OPW'(r_fs);
                        r_mm_b <= r_fr;
                        if (r_mode == MODE_FORK) begin
                            r_mand  <= '0;
                            r_state <= S_MMUL;
                        end else begin
                            r_mand  <= relay ? OPW'(r_fr) : OPW'(r_fs);
                            r_state <= S_MCHK;
                        end
                    end else if (l_cur < OPW'(2)) begin
                        r_lsel <= r_lsel + t_lsel'(1);
                    end else begin
                        r_div_go <= 1'b1;
                        r_div_a  <= r_n;
                        r_div_b  <= l_cur;
                        r_state  <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    if (r_d_done) begin
                        if (r_drem != '0) begin
                            r_lsel  <= r_lsel + t_lsel'(1);
                            r_state <= S_RSEL;
                        end else begin
                            r_pow_go <= 1'b1;
                            r_pow_e  <= r_dq;
                            r_state  <= S_RPOW;
                        end
                    end
                end
                S_RPOW: begin
                    if (r_pw_done) begin
                        if (r_px == W'(1)) begin
                            r_n <= r_dq;
                        end else begin
                            r_lsel <= r_lsel + t_lsel'(1);
                        end
                        r_state <= S_RSEL;
                    end
                end
                S_MMUL: begin
                    if (r_mm_b == '0) begin
                        r_state <= S_MCHK;
                    end else begin
                        if (r_mm_b[0]) r_mand <= r_mand + r_mm_a;
                        r_mm_a <= {r_mm_a[OPW-2:0], 1'b0};
                        r_mm_b <= {1'b0, r_mm_b[R_W-1:1]};
                    end
                end
                S_MCHK: begin
                    if (r_mand == '0) begin
                        r_verdict <= V_NOTMULT;
                        r_state   <= S_EMIT;
                    end else begin
                        r_div_go <= 1'b1;
                        r_div_a  <= r_n;
                        r_div_b  <= r_mand;
                        r_state  <= S_MDIV;
                    end
                end
                S_MDIV: begin
                    if (r_d_done) begin
                        r_verdict <= (r_drem == '0) ? V_HIT : V_NOTMULT;
                        r_state   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid   <= 1'b1;
                        r_out_cand    <= p_ext[CAND_W-1:0];
                        r_out_verdict <= r_verdict;
                        r_out_order   <= n_ext[CAND_W-1:0];
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_candidate_echo = r_out_cand;
    assign o_verdict        = r_out_verdict;
    assign o_order          = r_out_order;

    // binary gcd, one step a cycle, common power of two restored serially
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gst    <= G_IDLE;
            r_g_done <= 1'b0;
        end else begin
            r_g_done <= 1'b0;
            case (r_gst)
                G_IDLE: begin
                    if (r_gcd_go) begin
                        r_ga  <= r_gcd_a;
                        r_gb  <= r_gcd_b;
                        r_gk  <= '0;
                        r_gst <= G_RUN;
                    end
                end
                G_RUN: begin
                    if (r_ga == '0 || r_gb == '0) begin
                        if (r_ga == '0) r_ga <= r_gb;
                        if (r_gk == '0) begin
                            r_gst    <= G_IDLE;
                            r_g_done <= 1'b1;
                        end else begin
                            r_gst <= G_SHL;
                        end
                    end else if (!r_ga[0] && !r_gb[0]) begin
                        r_ga <= r_ga >> 1;
                        r_gb <= r_gb >> 1;
                        r_gk <= r_gk + KW'(1);
                    end else if (!r_ga[0]) begin
                        r_ga <= r_ga >> 1;
                    end else if (!r_gb[0]) begin
                        r_gb <= r_gb >> 1;
                    end else if (r_ga >= r_gb) begin
                        r_ga <= r_ga - r_gb;
                    end else begin
                        r_gb <= r_gb - r_ga;
                    end
                end
                G_SHL: begin
                    r_ga <= {r_ga[OPW-2:0], 1'b0};
                    r_gk <= r_gk - KW'(1);
                    if (r_gk == KW'(1)) begin
                        r_gst    <= G_IDLE;
                        r_g_done <= 1'b1;
                    end
                end
                default: r_gst <= G_IDLE;
            endcase
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [OPW:0] dsh;
    logic [OPW:0] dsub;
    logic         dge;

    assign dsh  = {r_drem, r_dq[W-1]};
    assign dge  = (dsh >= {1'b0, r_dd});
    assign dsub = dsh - {1'b0, r_dd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_busy <= 1'b0;
            r_d_done <= 1'b0;
        end else begin
            r_d_done <= 1'b0;
            if (r_div_go) begin
                r_dq     <= r_div_a;
                r_drem   <= '0;
                r_dd     <= r_div_b;
                r_dcnt   <= CW'(W);
                r_d_busy <= 1'b1;
            end else if (r_d_busy) begin
                r_drem <= dge ? dsub[OPW-1:0] : dsh[OPW-1:0];
                r_dq   <= {r_dq[W-2:0], dge};
                r_dcnt <= r_dcnt - CW'(1);
                if (r_dcnt == CW'(1)) begin
                    r_d_busy <= 1'b0;
                    r_d_done <= 1'b1;
                end
            end
        end
    end

    // 5^e mod p: square and multiply over a serial add-double multiplier
    logic [W-1:0] five_mod;
    logic [W:0]   m_add;
    logic [W:0]   m_dbl;
    logic [W-1:0] m_add_r;
    logic [W-1:0] m_dbl_r;

    always_comb begin
        case (r_p[2:0])
            3'd3:    five_mod = W'(2);
            3'd5:    five_mod = '0;
            default: five_mod = W'(1);
        endcase
        if (r_p >= W'(6)) five_mod = W'(5);
    end

    assign m_add   = {1'b0, r_macc} + {1'b0, r_ma};
    assign m_dbl   = {r_ma, 1'b0};
    assign m_add_r = (m_add >= {1'b0, r_p}) ? W'(m_add - {1'b0, r_p}) : m_add[W-1:0];
    assign m_dbl_r = (m_dbl >= {1'b0, r_p}) ? W'(m_dbl - {1'b0, r_p}) : m_dbl[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwst    <= PW_IDLE;
            r_pw_done <= 1'b0;
        end else begin
            r_pw_done <= 1'b0;
            case (r_pwst)
                PW_IDLE: begin
                    if (r_pow_go) begin
                        r_px   <= W'(1);
                        r_pb   <= five_mod;
                        r_pex  <= r_pow_e;
                        r_pwst <= PW_STEP;
                    end
                end
                PW_STEP: begin
                    r_macc <= '0;
                    if (r_pex == '0) begin
                        r_pw_done <= 1'b1;
                        r_pwst    <= PW_IDLE;
                    end else if (r_pex[0]) begin
                        r_pex   <= {r_pex[W-1:1], 1'b0};
                        r_ma    <= r_pb;
                        r_mb    <= r_px;
                        r_pw_sq <= 1'b0;
                        r_pwst  <= PW_MUL;
                    end else begin
                        r_pex   <= r_pex >> 1;
                        r_ma    <= r_pb;
                        r_mb    <= r_pb;
                        r_pw_sq <= 1'b1;
                        r_pwst  <= PW_MUL;
                    end
                end
                PW_MUL: begin
                    if (r_mb == '0) begin
                        if (r_pw_sq) r_pb <= r_macc;
                        else         r_px <= r_macc;
                        r_pwst <= PW_STEP;
                    end else begin
                        if (r_mb[0]) r_macc <= m_add_r;
                        r_ma <= m_dbl_r;
                        r_mb <= r_mb >> 1;
                    end
                end
                default: r_pwst <= PW_IDLE;
            endcase
        end
    end

    a_order_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_verdict == V_SMALL || o_verdict == V_POWER ||
                        o_verdict == V_COMPOSITE) |-> o_order == '0)
        else $error("order not cleared for early verdict");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> !r_d_busy)
        else $error("divider restarted while busy");

    a_pow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pw_done |-> r_px < r_p)
        else $error("power result not reduced");

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_g_done && r_state == S_GCD |-> r_ga != '0)
        else $error("gcd of zero operands");

    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_verdict <= V_HIT)
        else $error("verdict code out of range");

endmodule
